// ----- rtl/pwfd_pkg.sv -----
// Package: widths, reset values, register indexes, sequencer states and divider types.
package pwfd_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int DistW    = 16;
  localparam int TgtW     = 10;
  localparam int SpdW     = 7;
  localparam int GainW    = 16;
  localparam int StopW    = 8;
  localparam int ErrW     = 17;
  localparam int DiffW    = 18;
  localparam int FracW    = 8;
  localparam int DivW     = 25;
  localparam int DivCntW  = $clog2(DivW);
  localparam int MulAW    = 26;
  localparam int MulBW    = 17;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 40;
  localparam int WheelW   = SpdW + 1;

  localparam logic [TgtW-1:0]  TargetRst   = 10'd15;
  localparam logic [SpdW-1:0]  BaseRst     = 7'd40;
  localparam logic [GainW-1:0] PropRst     = 16'd1587;
  localparam logic [GainW-1:0] IntegRst    = 16'd128;
  localparam logic [GainW-1:0] DerivRst    = 16'd256;
  localparam logic [SpdW-1:0]  SpeedLimRst = 7'd50;
  localparam logic [GainW-1:0] IntegLimRst = 16'd1;
  localparam logic [StopW-1:0] StopRst     = 8'd2;

  localparam logic [CfgIdxW-1:0] CFG_TARGET    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROP      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTEG     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DERIV     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_LIM = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_LIM = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_STOP      = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_EDT,
    S_M_PE,
    S_M_IE,
    S_ACC_I,
    S_DIV,
    S_M_D,
    S_ACC_D,
    S_LEFT,
    S_RIGHT,
    S_FIN
  } pwfd_state_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DistW-1:0] divisor;
  } pwfd_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } pwfd_div_rsp_t;

endpackage

// ----- rtl/pwfd_if.sv -----
// Interfaces: sample request channel and motor command channel.
interface pwfd_in_if import pwfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] side_distance;
  logic [DistW-1:0] front_distance;
  logic [DistW-1:0] elapsed_ms;

  modport source (output valid, side_distance, front_distance, elapsed_ms, input ready);
  modport sink (input valid, side_distance, front_distance, elapsed_ms, output ready);
endinterface

interface pwfd_out_if import pwfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            left_reverse;
  logic [SpdW-1:0] left_pwm;
  logic            right_reverse;
  logic [SpdW-1:0] right_pwm;
  logic            drive_enable;

  modport source (output valid, left_reverse, left_pwm, right_reverse, right_pwm,
                  drive_enable, input ready);
  modport sink (input valid, left_reverse, left_pwm, right_reverse, right_pwm,
                drive_enable, output ready);
endinterface

// ----- rtl/pwfd_div.sv -----
// Restoring divider: one quotient bit per cycle, unsigned operands.
module pwfd_div import pwfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  pwfd_div_req_t req,
  output pwfd_div_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0]    quo_r, quo_nxt;
  logic [DistW-1:0]   rem_r, rem_nxt;
  logic [DistW-1:0]   dvs_r, dvs_nxt;
  logic [DistW:0]     rem_sh;
  logic               ge;

  assign rem_sh = {rem_r, quo_r[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DivW-2:0], ge};
      rem_nxt = ge ? DistW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DistW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DivCntW'(DivW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/pid_wall_follow_drive_top.sv -----
// Wall-following PID controller for a two-wheel differential drive.
// One sample request is taken at a time: a small sequencer runs the error, the clamped integral,
// the derivative and the wheel mix through one shared 26x17 multiplier and a restoring
// divider. A driving sample passes from the accepting edge to out_ch.valid through the 25
// divider steps for the derivative, its load and hand-off, four passes through the
// multiplier and the two wheel mix steps; with elapsed_ms of zero the divider is skipped,
// and a stop sample (front_distance at or below the CFG_STOP register) goes straight to the
// final state. in_ch.ready rises with out_ch.valid, so the next request can be accepted from
// then on. The result sits in an output register, so the next request is accepted while it
// waits. Registers are written through cfg_we, cfg_addr and cfg_wdata; the user must write
// them only while the block is idle, and the block itself does not enforce it.
module pid_wall_follow_drive_top import pwfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  pwfd_in_if.sink             in_ch,
  pwfd_out_if.source          out_ch
);

  logic [TgtW-1:0]  target_r;
  logic [SpdW-1:0]  base_r;
  logic [GainW-1:0] prop_r;
  logic [GainW-1:0] integ_gain_r;
  logic [GainW-1:0] deriv_r;
  logic [SpdW-1:0]  speed_lim_r;
  logic [GainW-1:0] integ_lim_r;
  logic [StopW-1:0] stop_r;

  pwfd_state_t state_r, state_nxt;

  logic signed [ErrW-1:0]  integ_r, integ_nxt;
  logic signed [ErrW-1:0]  prev_err_r, prev_err_nxt;
  logic signed [ErrW-1:0]  err_r, err_nxt;
  logic [DistW-1:0]        dt_r, dt_nxt;
  logic signed [ErrW-1:0]  inew_r, inew_nxt;
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic signed [MulAW-1:0] d8_r, d8_nxt;
  logic                    dneg_r, dneg_nxt;
  logic                    halt_r, halt_nxt;

  logic            res_lrev_r, res_lrev_nxt;
  logic [SpdW-1:0] res_lpwm_r, res_lpwm_nxt;
  logic            res_rrev_r, res_rrev_nxt;
  logic [SpdW-1:0] res_rpwm_r, res_rpwm_nxt;
  logic            res_en_r, res_en_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_lrev_r, out_lrev_nxt;
  logic [SpdW-1:0] out_lpwm_r, out_lpwm_nxt;
  logic            out_rrev_r, out_rrev_nxt;
  logic [SpdW-1:0] out_rpwm_r, out_rpwm_nxt;
  logic            out_en_r, out_en_nxt;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_nxt;

  logic signed [ProdW-1:0] isum, ilim, iclamp;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        diff_abs;
  logic signed [ProdW-1:0] dterm;
  logic signed [ProdW-1:0] base_q, mix_v, mix_t, slim, mix_c;
  logic signed [WheelW-1:0] wheel;
  logic                    wheel_rev;
  logic [SpdW-1:0]         wheel_pwm;

  logic          in_fire;
  logic          stop_hit;
  pwfd_div_req_t div_req;
  pwfd_div_rsp_t div_rsp;

  function automatic logic signed [ProdW-1:0] shr_trunc0(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] b;
    b = v + (v[ProdW-1] ? ProdW'((1 << FracW) - 1) : ProdW'(0));
    return b >>> FracW;
  endfunction

  pwfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TargetRst;
      base_r       <= BaseRst;
      prop_r       <= PropRst;
      integ_gain_r <= IntegRst;
      deriv_r      <= DerivRst;
      speed_lim_r  <= SpeedLimRst;
      integ_lim_r  <= IntegLimRst;
      stop_r       <= StopRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TARGET:    target_r     <= cfg_wdata[TgtW-1:0];
        CFG_BASE:      base_r       <= cfg_wdata[SpdW-1:0];
        CFG_PROP:      prop_r       <= cfg_wdata[GainW-1:0];
        CFG_INTEG:     integ_gain_r <= cfg_wdata[GainW-1:0];
        CFG_DERIV:     deriv_r      <= cfg_wdata[GainW-1:0];
        CFG_SPEED_LIM: speed_lim_r  <= cfg_wdata[SpdW-1:0];
        CFG_INTEG_LIM: integ_lim_r  <= cfg_wdata[GainW-1:0];
        CFG_STOP:      stop_r       <= cfg_wdata[StopW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign stop_hit    = in_ch.front_distance <= DistW'(stop_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M_EDT: begin
        mul_a = MulAW'(err_r);
        mul_b = $signed({1'b0, dt_r});
      end
      S_M_PE: begin
        mul_a = MulAW'(err_r);
        mul_b = $signed({1'b0, prop_r});
      end
      S_M_IE: begin
        mul_a = MulAW'(inew_r);
        mul_b = $signed({1'b0, integ_gain_r});
      end
      S_M_D: begin
        mul_a = d8_r;
        mul_b = $signed({1'b0, deriv_r});
      end
      default: ;
    endcase
  end

  assign prod_nxt = ProdW'(mul_a) * ProdW'(mul_b);

  assign isum   = ProdW'(integ_r) + prod_r;
  assign ilim   = $signed(ProdW'(integ_lim_r));
  assign iclamp = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);

  assign diff     = DiffW'(err_r) - DiffW'(prev_err_r);
  assign diff_abs = diff[DiffW-1] ? DiffW'(-diff) : diff;

  assign dterm = shr_trunc0(prod_r);

  assign base_q = $signed(ProdW'({base_r, {FracW{1'b0}}}));
  assign mix_v  = (state_r == S_LEFT) ? base_q - ProdW'(acc_r) : base_q + ProdW'(acc_r);
  assign mix_t  = shr_trunc0(mix_v);
  assign slim   = $signed(ProdW'(speed_lim_r));
  assign mix_c  = (mix_t > slim) ? slim : ((mix_t < -slim) ? -slim : mix_t);
  assign wheel  = mix_c[WheelW-1:0];
  assign wheel_rev = wheel[WheelW-1] || (wheel == '0);
  assign wheel_pwm = wheel[WheelW-1] ? SpdW'(-wheel) : wheel[SpdW-1:0];

  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    inew_nxt      = inew_r;
    acc_nxt       = acc_r;
    d8_nxt        = d8_r;
    dneg_nxt      = dneg_r;
    halt_nxt      = halt_r;
    res_lrev_nxt  = res_lrev_r;
    res_lpwm_nxt  = res_lpwm_r;
    res_rrev_nxt  = res_rrev_r;
    res_rpwm_nxt  = res_rpwm_r;
    res_en_nxt    = res_en_r;
    out_valid_nxt = out_valid_r;
    out_lrev_nxt  = out_lrev_r;
    out_lpwm_nxt  = out_lpwm_r;
    out_rrev_nxt  = out_rrev_r;
    out_rpwm_nxt  = out_rpwm_r;
    out_en_nxt    = out_en_r;
    div_req.start    = 1'b0;
    div_req.dividend = {diff_abs[DivW-FracW-1:0], {FracW{1'b0}}};
    div_req.divisor  = dt_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          err_nxt  = $signed({{(ErrW-TgtW){1'b0}}, target_r}) -
                     $signed({1'b0, in_ch.side_distance});
          dt_nxt   = in_ch.elapsed_ms;
          halt_nxt = stop_hit;
          if (stop_hit) begin
            res_lrev_nxt = 1'b0;
            res_lpwm_nxt = '0;
            res_rrev_nxt = 1'b0;
            res_rpwm_nxt = '0;
            res_en_nxt   = 1'b0;
            state_nxt    = S_FIN;
          end else begin
            res_en_nxt = 1'b1;
            state_nxt  = S_M_EDT;
          end
        end
      end
      S_M_EDT: state_nxt = S_M_PE;
      S_M_PE: begin
        inew_nxt  = iclamp[ErrW-1:0];
        state_nxt = S_M_IE;
      end
      S_M_IE: begin
        acc_nxt   = AccW'(prod_r);
        state_nxt = S_ACC_I;
      end
      S_ACC_I: begin
        acc_nxt  = acc_r + AccW'(prod_r);
        dneg_nxt = diff[DiffW-1];
        if (dt_r == '0) begin
          d8_nxt    = '0;
          state_nxt = S_M_D;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          d8_nxt    = dneg_r ? -$signed({1'b0, div_rsp.quotient})
                             : $signed({1'b0, div_rsp.quotient});
          state_nxt = S_M_D;
        end
      end
      S_M_D: state_nxt = S_ACC_D;
      S_ACC_D: begin
        acc_nxt   = acc_r + AccW'(dterm);
        state_nxt = S_LEFT;
      end
      S_LEFT: begin
        res_lrev_nxt = wheel_rev;
        res_lpwm_nxt = wheel_pwm;
        state_nxt    = S_RIGHT;
      end
      S_RIGHT: begin
        res_rrev_nxt = wheel_rev;
        res_rpwm_nxt = wheel_pwm;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_lrev_nxt  = res_lrev_r;
          out_lpwm_nxt  = res_lpwm_r;
          out_rrev_nxt  = res_rrev_r;
          out_rpwm_nxt  = res_rpwm_r;
          out_en_nxt    = res_en_r;
          if (!halt_r) begin
            integ_nxt    = inew_r;
            prev_err_nxt = err_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integ_r     <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r      <= err_nxt;
    dt_r       <= dt_nxt;
    inew_r     <= inew_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    d8_r       <= d8_nxt;
    dneg_r     <= dneg_nxt;
    halt_r     <= halt_nxt;
    res_lrev_r <= res_lrev_nxt;
    res_lpwm_r <= res_lpwm_nxt;
    res_rrev_r <= res_rrev_nxt;
    res_rpwm_r <= res_rpwm_nxt;
    res_en_r   <= res_en_nxt;
    out_lrev_r <= out_lrev_nxt;
    out_lpwm_r <= out_lpwm_nxt;
    out_rrev_r <= out_rrev_nxt;
    out_rpwm_r <= out_rpwm_nxt;
    out_en_r   <= out_en_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_reverse  = out_lrev_r;
  assign out_ch.left_pwm      = out_lpwm_r;
  assign out_ch.right_reverse = out_rrev_r;
  assign out_ch.right_pwm     = out_rpwm_r;
  assign out_ch.drive_enable  = out_en_r;

endmodule

// ----- tb/sv/pid_wall_follow_drive_top_tb.sv -----
// Testbench for pid_wall_follow_drive_top: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module pid_wall_follow_drive_top_tb;
  import pwfd_pkg::*;

  typedef struct packed {
    logic            left_reverse;
    logic [SpdW-1:0] left_pwm;
    logic            right_reverse;
    logic [SpdW-1:0] right_pwm;
    logic            drive_enable;
  } motor_cmd_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  addr;
    logic [CfgDataW-1:0] wdata;
    logic [DistW-1:0]    side;
    logic [DistW-1:0]    front;
    logic [DistW-1:0]    dt;
    logic                typed;
    motor_cmd_t          want;
  } step_row_t;

  localparam int NumPhases  = 24;
  localparam int PerPhase   = 76;
  localparam int StallLimit = 3000;
  localparam int TailCycles = 60;

  localparam motor_cmd_t MotorsOff   = '0;
  localparam motor_cmd_t Cruise      = '{1'b0, 7'd40, 1'b0, 7'd40, 1'b1};
  localparam motor_cmd_t VeerRight   = '{1'b0, 7'd50, 1'b1, 7'd50, 1'b1};
  localparam motor_cmd_t VeerLeft    = '{1'b1, 7'd50, 1'b0, 7'd50, 1'b1};
  localparam motor_cmd_t WheelsZero  = '{1'b1, 7'd0, 1'b1, 7'd0, 1'b1};

  localparam int NumRows = 35;
  localparam step_row_t Plan [NumRows] = '{
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd100, 16'd0, 1'b1, Cruise},
    '{1'b0, CFG_TARGET, 16'd0, 16'd0, 16'd2, 16'd0, 1'b1, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd65535, 16'd0, 16'd65535, 1'b1, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd3, 16'd10, 1'b1, Cruise},
    '{1'b0, CFG_TARGET, 16'd0, 16'd65535, 16'd65535, 16'd65535, 1'b1, VeerRight},
    '{1'b0, CFG_TARGET, 16'd0, 16'd0, 16'd65535, 16'd1, 1'b1, VeerLeft},
    '{1'b0, CFG_TARGET, 16'd0, 16'd0, 16'd65535, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd500, 16'd1, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd20, 16'd500, 16'd5, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd10, 16'd40, 16'd3, 1'b0, MotorsOff},
    '{1'b1, CFG_SPEED_LIM, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd30, 16'd400, 16'd7, 1'b1, WheelsZero},
    '{1'b1, CFG_SPEED_LIM, 16'd127, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_BASE, 16'd127, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd400, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_INTEG_LIM, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd10, 16'd400, 16'd100, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd25, 16'd400, 16'd9, 1'b0, MotorsOff},
    '{1'b1, CFG_STOP, 16'd255, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd255, 16'd4, 1'b1, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd15, 16'd256, 16'd4, 1'b0, MotorsOff},
    '{1'b1, CFG_TARGET, 16'd1023, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd0, 16'd1000, 16'd2, 1'b0, MotorsOff},
    '{1'b1, CFG_TARGET, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd65535, 16'd1000, 16'd65535, 1'b0, MotorsOff},
    '{1'b1, CFG_PROP, 16'd65535, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_INTEG, 16'd65535, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_DERIV, 16'd65535, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd40000, 16'd60000, 16'd1, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd0, 16'd60000, 16'd1, 1'b0, MotorsOff},
    '{1'b1, CFG_BASE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_PROP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_INTEG, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b1, CFG_DERIV, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, MotorsOff},
    '{1'b0, CFG_TARGET, 16'd0, 16'd1234, 16'd700, 16'd3, 1'b1, WheelsZero}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  pwfd_in_if  in_ch ();
  pwfd_out_if out_ch ();

  pid_wall_follow_drive_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [TgtW-1:0]  target_cm = TargetRst;
  logic [SpdW-1:0]  base_spd  = BaseRst;
  logic [GainW-1:0] kp        = PropRst;
  logic [GainW-1:0] ki        = IntegRst;
  logic [GainW-1:0] kd        = DerivRst;
  logic [SpdW-1:0]  spd_lim   = SpeedLimRst;
  logic [GainW-1:0] int_lim   = IntegLimRst;
  logic [StopW-1:0] stop_cm   = StopRst;
  longint           err_sum   = 0;
  longint           last_err  = 0;

  motor_cmd_t motor_cmds_due [$];
  motor_cmd_t head_cmd;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         drain_hold   = 0;
  bit         steady       = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_sym(input longint v, input longint bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  function automatic motor_cmd_t steer_for_sample(input logic [DistW-1:0] side,
                                                  input logic [DistW-1:0] front,
                                                  input logic [DistW-1:0] dt);
    longint     err, integ, slope8, corr8, left, right;
    motor_cmd_t cmd;
    cmd = MotorsOff;
    if (longint'(front) <= longint'(stop_cm)) return cmd;
    err    = longint'(target_cm) - longint'(side);
    integ  = clamp_sym(err_sum + err * longint'(dt), longint'(int_lim));
    slope8 = (dt != 0) ? ((err - last_err) * 256) / longint'(dt) : 0;
    corr8  = longint'(kp) * err + longint'(ki) * integ + (longint'(kd) * slope8) / 256;
    left   = clamp_sym((longint'(base_spd) * 256 - corr8) / 256, longint'(spd_lim));
    right  = clamp_sym((longint'(base_spd) * 256 + corr8) / 256, longint'(spd_lim));
    err_sum  = integ;
    last_err = err;
    cmd.left_reverse  = (left <= 0);
    cmd.left_pwm      = SpdW'(left < 0 ? -left : left);
    cmd.right_reverse = (right <= 0);
    cmd.right_pwm     = SpdW'(right < 0 ? -right : right);
    cmd.drive_enable  = 1'b1;
    return cmd;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CfgDataW-1:0] phase_reg_value(input int ph,
                                                          input logic [CfgIdxW-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    if (ph == 0 || (ph > 2 && r == 0)) return '1;
    if (ph == 1 || (ph > 2 && r == 1)) return '0;
    if (ph > 2 && r == 2) return CfgDataW'($urandom);
    case (idx)
      CFG_TARGET:    return (ph == 2) ? CfgDataW'(TargetRst)
                                      : CfgDataW'($urandom_range(0, 60));
      CFG_BASE:      return (ph == 2) ? CfgDataW'(BaseRst)
                                      : CfgDataW'($urandom_range(10, 80));
      CFG_PROP:      return (ph == 2) ? CfgDataW'(PropRst)
                                      : CfgDataW'($urandom_range(0, 2048));
      CFG_INTEG:     return (ph == 2) ? CfgDataW'(IntegRst)
                                      : CfgDataW'($urandom_range(0, 512));
      CFG_DERIV:     return (ph == 2) ? CfgDataW'(DerivRst)
                                      : CfgDataW'($urandom_range(0, 1024));
      CFG_SPEED_LIM: return (ph == 2) ? CfgDataW'(SpeedLimRst)
                                      : CfgDataW'($urandom_range(10, 127));
      CFG_INTEG_LIM: return (ph == 2) ? CfgDataW'(IntegLimRst)
                                      : CfgDataW'($urandom_range(0, 3000));
      default:       return (ph == 2) ? CfgDataW'(StopRst)
                                      : CfgDataW'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (motor_cmds_due.size() != 0);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET:    target_cm = val[TgtW-1:0];
      CFG_BASE:      base_spd  = val[SpdW-1:0];
      CFG_PROP:      kp        = val[GainW-1:0];
      CFG_INTEG:     ki        = val[GainW-1:0];
      CFG_DERIV:     kd        = val[GainW-1:0];
      CFG_SPEED_LIM: spd_lim   = val[SpdW-1:0];
      CFG_INTEG_LIM: int_lim   = val[GainW-1:0];
      CFG_STOP:      stop_cm   = val[StopW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [DistW-1:0] side, input logic [DistW-1:0] front,
                             input logic [DistW-1:0] dt, input logic typed,
                             input motor_cmd_t want);
    int         gap;
    motor_cmd_t calc;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.side_distance  <= side;
    in_ch.front_distance <= front;
    in_ch.elapsed_ms     <= dt;
    do @(posedge clk); while (!in_ch.ready);
    calc = steer_for_sample(side, front, dt);
    motor_cmds_due.push_back(typed ? want : calc);
  endtask

  // hold ready low for random stretches unless the phase runs steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      drain_hold   <= 0;
    end else if (drain_hold != 0) begin
      out_ch.ready <= 1'b0;
      drain_hold   <= drain_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) drain_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (motor_cmds_due.size() == 0) begin
        $display("%0t: motor command with none pending: l=%0d/%0d r=%0d/%0d en=%0d", $time,
                 out_ch.left_reverse, out_ch.left_pwm, out_ch.right_reverse,
                 out_ch.right_pwm, out_ch.drive_enable);
        mismatches++;
      end else begin
        head_cmd = motor_cmds_due.pop_front();
        check_field("left_reverse", 8'(head_cmd.left_reverse), 8'(out_ch.left_reverse));
        check_field("left_pwm", 8'(head_cmd.left_pwm), 8'(out_ch.left_pwm));
        check_field("right_reverse", 8'(head_cmd.right_reverse), 8'(out_ch.right_reverse));
        check_field("right_pwm", 8'(head_cmd.right_pwm), 8'(out_ch.right_pwm));
        check_field("drive_enable", 8'(head_cmd.drive_enable), 8'(out_ch.drive_enable));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("** pid_wall_follow_drive_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               ph, n, r, v;
    logic [DistW-1:0] side, front, dt;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_addr             <= '0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.side_distance  <= '0;
    in_ch.front_distance <= '0;
    in_ch.elapsed_ms     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].is_cfg) write_reg(Plan[i].addr, Plan[i].wdata);
      else send_sample(Plan[i].side, Plan[i].front, Plan[i].dt, Plan[i].typed, Plan[i].want);
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      steady = (ph % 4 == 1);
      for (int idx = 0; idx < 8; idx++) begin
        write_reg(CfgIdxW'(idx), phase_reg_value(ph, CfgIdxW'(idx)));
      end
      for (n = 0; n < PerPhase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          v = int'(target_cm);
          v = v + int'($urandom_range(0, 80)) - 40;
          side = (v < 0) ? '0 : DistW'(v);
        end else if (r < 85) begin
          side = DistW'($urandom_range(0, 65535));
        end else if (r < 92) begin
          side = DistW'($urandom_range(0, 15));
        end else begin
          side = DistW'(16'hFFFF - $urandom_range(0, 15));
        end
        r = $urandom_range(0, 99);
        if (r < 75) front = DistW'($urandom_range(int'(stop_cm) + 1, 3000));
        else if (r < 85) front = DistW'($urandom_range(0, int'(stop_cm)));
        else if (r < 95) front = DistW'($urandom_range(0, 65535));
        else front = DistW'(16'hFFFF - $urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 10) dt = '0;
        else if (r < 70) dt = DistW'($urandom_range(1, 60));
        else if (r < 90) dt = DistW'($urandom_range(61, 1000));
        else dt = DistW'($urandom_range(0, 65535));
        send_sample(side, front, dt, 1'b0, MotorsOff);
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (motor_cmds_due.size() != 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("** pid_wall_follow_drive_top: PASSED **");
    end else begin
      $display("** pid_wall_follow_drive_top: FAILED **");
    end
    $finish;
  end

endmodule
